>>> sv/tllrl_pkg.sv
`timescale 1ns / 1ps

package tllrl_pkg;

  // table geometry, both sizes powers of two
  localparam int unsigned ADDR_SLOTS = 1024;
  localparam int unsigned PAIR_SLOTS = 4096;
  localparam int unsigned ADDR_W     = $clog2(ADDR_SLOTS);
  localparam int unsigned PAIR_W     = $clog2(PAIR_SLOTS);
  localparam int unsigned CLR_SLOTS  = (ADDR_SLOTS > PAIR_SLOTS) ? ADDR_SLOTS : PAIR_SLOTS;
  localparam int unsigned CLR_W      = $clog2(CLR_SLOTS);

  // field widths
  localparam int unsigned NOW_W      = 47;
  localparam int unsigned TIME_W     = 48;
  localparam int unsigned BURST_W    = 8;
  localparam int unsigned IV_W       = 18;
  localparam int unsigned PROD_W     = BURST_W + IV_W;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = IV_W;
  localparam int unsigned VERDICT_W  = 2;

  // register reset values
  localparam logic [BURST_W-1:0] ADDR_BURST_RST = 8'd5;
  localparam logic [IV_W-1:0]    ADDR_IV_RST    = 18'd1000;
  localparam logic [BURST_W-1:0] PAIR_BURST_RST = 8'd2;
  localparam logic [IV_W-1:0]    PAIR_IV_RST    = 18'd500;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ADDR_BURST = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ADDR_IV    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PAIR_BURST = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PAIR_IV    = 2'd3;

  // verdict codes
  localparam logic [VERDICT_W-1:0] VERDICT_ALLOW     = 2'd0;
  localparam logic [VERDICT_W-1:0] VERDICT_DENY_ADDR = 2'd1;
  localparam logic [VERDICT_W-1:0] VERDICT_DENY_PAIR = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOAD,
    ST_EVAL,
    ST_PUSH
  } state_e;

endpackage

>>> sv/two_level_login_rate_limiter.sv
`timescale 1ns / 1ps

// two-level login rate limiter: a cell rate (token bucket) check per source
// address, then per address-and-account pair, each slot holding the time at
// which its bucket is full again. both tables are read at accept, then the
// load state forms the clamped time and the bound, then the eval state
// compares, writes back and loads or parks the result; the block returns to
// idle before the next word is taken, so a new word waits until the last one
// has been judged, and a stalled result holds the block in the push state.
// after reset both tables are swept to zero, one entry per cycle, during
// which no request word is taken (register writes are always taken).
// registers: 0 address burst, 1 address interval in ms, 2 pair burst, 3 pair
// interval in ms; a burst of zero turns that check off. verdict 0 allowed,
// 1 denied by address, 2 denied by pair.
module two_level_login_rate_limiter import tllrl_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // request words
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [NOW_W-1:0]      now_ms_i,
  input  logic [9:0]            addr_slot_i,
  input  logic [11:0]           pair_slot_i,
  // result words
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [VERDICT_W-1:0]  verdict_o,
  // register writes
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  // slot tables
  logic [TIME_W-1:0] addr_mem [ADDR_SLOTS];
  logic [TIME_W-1:0] pair_mem [PAIR_SLOTS];

  state_e state_q, state_d;

  // configuration
  logic [BURST_W-1:0] addr_burst_q, pair_burst_q;
  logic [IV_W-1:0]    addr_iv_q, pair_iv_q;

  // captured request
  logic [NOW_W-1:0]  now_q;
  logic [ADDR_W-1:0] addr_slot_q;
  logic [PAIR_W-1:0] pair_slot_q;

  // table read data
  logic [TIME_W-1:0] addr_rd_q, pair_rd_q;

  // clamped ready times and deny bounds
  logic [TIME_W-1:0] addr_t_q, addr_t_d, pair_t_q, pair_t_d;
  logic [TIME_W-1:0] addr_bnd_q, addr_bnd_d, pair_bnd_q, pair_bnd_d;

  // sweep counter
  logic [CLR_W-1:0] clr_cnt_q, clr_cnt_d;
  logic             clr_last;

  // output register and parked verdict
  logic                 out_valid_q, out_valid_d;
  logic [VERDICT_W-1:0] verdict_q, verdict_d;
  logic [VERDICT_W-1:0] res_q, res_d;
  logic                 out_free;

  // control
  logic                 in_accept;
  logic                 addr_we, pair_we;
  logic [ADDR_W-1:0]    addr_wa;
  logic [PAIR_W-1:0]    pair_wa;
  logic [TIME_W-1:0]    addr_wd, pair_wd;
  logic                 out_load;

  // check results
  logic                 addr_on, pair_on, pair_run;
  logic [TIME_W:0]      addr_sum, pair_sum;
  logic                 addr_deny, pair_deny;
  logic [VERDICT_W-1:0] verdict_new;
  logic [PROD_W-1:0]    addr_prod, pair_prod;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign verdict_o   = verdict_q;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign clr_last    = (clr_cnt_q == CLR_W'(CLR_SLOTS - 1));

  // ---------------------------------------------------------------------------
  // register writes, masked to register width
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_burst_q <= ADDR_BURST_RST;
      addr_iv_q    <= ADDR_IV_RST;
      pair_burst_q <= PAIR_BURST_RST;
      pair_iv_q    <= PAIR_IV_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_ADDR_BURST: addr_burst_q <= cfg_data_i[BURST_W-1:0];
        CFG_ADDR_IV:    addr_iv_q    <= cfg_data_i[IV_W-1:0];
        CFG_PAIR_BURST: pair_burst_q <= cfg_data_i[BURST_W-1:0];
        CFG_PAIR_IV:    pair_iv_q    <= cfg_data_i[IV_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // datapath: load stage clamps and forms the bound, eval stage compares
  // ---------------------------------------------------------------------------
  assign addr_prod = PROD_W'(addr_iv_q) * PROD_W'(addr_burst_q);
  assign pair_prod = PROD_W'(pair_iv_q) * PROD_W'(pair_burst_q);

  always_comb begin
    // stored time raised to at least now
    addr_t_d   = (addr_rd_q < TIME_W'(now_q)) ? TIME_W'(now_q) : addr_rd_q;
    pair_t_d   = (pair_rd_q < TIME_W'(now_q)) ? TIME_W'(now_q) : pair_rd_q;
    // now + interval * burst, fits in 48 bits
    addr_bnd_d = TIME_W'(now_q) + TIME_W'(addr_prod);
    pair_bnd_d = TIME_W'(now_q) + TIME_W'(pair_prod);
  end

  always_comb begin
    addr_on     = (addr_burst_q != '0);
    pair_on     = (pair_burst_q != '0);
    addr_sum    = (TIME_W+1)'(addr_t_q) + (TIME_W+1)'(addr_iv_q);
    pair_sum    = (TIME_W+1)'(pair_t_q) + (TIME_W+1)'(pair_iv_q);
    addr_deny   = addr_on && (addr_sum > (TIME_W+1)'(addr_bnd_q));
    // address denial leaves the pair table untouched
    pair_run    = !addr_deny && pair_on;
    pair_deny   = pair_run && (pair_sum > (TIME_W+1)'(pair_bnd_q));
    verdict_new = addr_deny ? VERDICT_DENY_ADDR :
                  pair_deny ? VERDICT_DENY_PAIR : VERDICT_ALLOW;
  end

  // ---------------------------------------------------------------------------
  // state machine: next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: if (clr_last) state_d = ST_IDLE;
      ST_IDLE:  if (in_accept) state_d = ST_LOAD;
      ST_LOAD:  state_d = ST_EVAL;
      ST_EVAL:  state_d = out_free ? ST_IDLE : ST_PUSH;
      ST_PUSH:  if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_CLEAR;
    endcase
  end

  // ---------------------------------------------------------------------------
  // state machine: outputs (table writes, result load, sweep)
  // ---------------------------------------------------------------------------
  always_comb begin
    addr_we   = 1'b0;
    pair_we   = 1'b0;
    addr_wa   = addr_slot_q;
    pair_wa   = pair_slot_q;
    addr_wd   = addr_deny ? addr_t_q : addr_sum[TIME_W-1:0];
    pair_wd   = pair_deny ? pair_t_q : pair_sum[TIME_W-1:0];
    out_load  = 1'b0;
    verdict_d = verdict_q;
    res_d     = res_q;
    clr_cnt_d = clr_cnt_q;
    case (state_q)
      ST_CLEAR: begin
        addr_we   = 1'b1;
        pair_we   = 1'b1;
        addr_wa   = clr_cnt_q[ADDR_W-1:0];
        pair_wa   = clr_cnt_q[PAIR_W-1:0];
        addr_wd   = '0;
        pair_wd   = '0;
        clr_cnt_d = clr_cnt_q + CLR_W'(1);
      end
      ST_EVAL: begin
        addr_we = addr_on;
        pair_we = pair_run;
        res_d   = verdict_new;
        if (out_free) begin
          out_load  = 1'b1;
          verdict_d = verdict_new;
        end
      end
      ST_PUSH: begin
        if (out_free) begin
          out_load  = 1'b1;
          verdict_d = res_q;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // control registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      now_q       <= now_ms_i;
      addr_slot_q <= addr_slot_i[ADDR_W-1:0];
      pair_slot_q <= pair_slot_i[PAIR_W-1:0];
    end
    if (state_q == ST_LOAD) begin
      addr_t_q   <= addr_t_d;
      pair_t_q   <= pair_t_d;
      addr_bnd_q <= addr_bnd_d;
      pair_bnd_q <= pair_bnd_d;
    end
    verdict_q <= verdict_d;
    res_q     <= res_d;
  end

  // ---------------------------------------------------------------------------
  // slot tables, one write and one registered read each
  // both are read on accept; write-back lands before the next accept
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (addr_we) begin
      addr_mem[addr_wa] <= addr_wd;
    end
    if (in_accept) begin
      addr_rd_q <= addr_mem[addr_slot_i[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pair_we) begin
      pair_mem[pair_wa] <= pair_wd;
    end
    if (in_accept) begin
      pair_rd_q <= pair_mem[pair_slot_i[PAIR_W-1:0]];
    end
  end

endmodule

>>> sim/tllrl_verdict_tracker.sv
`timescale 1ns / 1ps

module tllrl_verdict_tracker import tllrl_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  logic [NOW_W-1:0]      now_ms_i,
  input  logic [9:0]            addr_slot_i,
  input  logic [11:0]           pair_slot_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  logic [VERDICT_W-1:0]  verdict_i,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int                    fail_count_o,
  output int                    pending_o
);

  // ready time per slot: when the bucket is full again
  logic [TIME_W-1:0]    addr_ready [ADDR_SLOTS];
  logic [TIME_W-1:0]    pair_ready [PAIR_SLOTS];
  logic [BURST_W-1:0]   addr_burst;
  logic [IV_W-1:0]      addr_iv;
  logic [BURST_W-1:0]   pair_burst;
  logic [IV_W-1:0]      pair_iv;
  logic [VERDICT_W-1:0] verdict_q [$];
  logic [VERDICT_W-1:0] want_verdict;

  // msb set on deny, low bits the new ready time
  function automatic logic [TIME_W:0] bucket_take(input logic [TIME_W-1:0] ready,
                                                  input logic [NOW_W-1:0] now,
                                                  input logic [BURST_W-1:0] burst,
                                                  input logic [IV_W-1:0] iv);
    logic [63:0] t;
    logic [63:0] bound;
    t = 64'(ready);
    if (t < 64'(now)) t = 64'(now);
    bound = 64'(now) + 64'(iv) * 64'(burst);
    if (t + 64'(iv) > bound) return {1'b1, t[TIME_W-1:0]};
    t = t + 64'(iv);
    return {1'b0, t[TIME_W-1:0]};
  endfunction

  // address check first; a deny there leaves the pair table alone
  function automatic logic [VERDICT_W-1:0] judge_request(input logic [NOW_W-1:0] now,
                                                         input logic [9:0] a,
                                                         input logic [11:0] p);
    logic [TIME_W:0] r;
    if (addr_burst != '0) begin
      r = bucket_take(addr_ready[a], now, addr_burst, addr_iv);
      addr_ready[a] = r[TIME_W-1:0];
      if (r[TIME_W]) return VERDICT_DENY_ADDR;
    end
    if (pair_burst != '0) begin
      r = bucket_take(pair_ready[p], now, pair_burst, pair_iv);
      pair_ready[p] = r[TIME_W-1:0];
      if (r[TIME_W]) return VERDICT_DENY_PAIR;
    end
    return VERDICT_ALLOW;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (addr_ready[i]) addr_ready[i] = '0;
      foreach (pair_ready[i]) pair_ready[i] = '0;
      addr_burst   = ADDR_BURST_RST;
      addr_iv      = ADDR_IV_RST;
      pair_burst   = PAIR_BURST_RST;
      pair_iv      = PAIR_IV_RST;
      verdict_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_ADDR_BURST: addr_burst = cfg_data_i[BURST_W-1:0];
          CFG_ADDR_IV:    addr_iv    = cfg_data_i[IV_W-1:0];
          CFG_PAIR_BURST: pair_burst = cfg_data_i[BURST_W-1:0];
          CFG_PAIR_IV:    pair_iv    = cfg_data_i[IV_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        verdict_q.push_back(judge_request(now_ms_i, addr_slot_i, pair_slot_i));
      end
      if (out_valid_i && !out_stall_i) begin
        if (verdict_q.size() == 0) begin
          $error("verdict word with nothing expected: actual %0d", verdict_i);
          fail_count_o++;
        end else begin
          want_verdict = verdict_q.pop_front();
          if (verdict_i !== want_verdict) begin
            $error("verdict mismatch: expected %0d actual %0d", want_verdict, verdict_i);
            fail_count_o++;
          end
        end
      end
      pending_o = verdict_q.size();
    end
  end

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top import tllrl_pkg::*;;

  // no-progress limit; covers the table sweep after reset and the long result
  // hold-off with a wide margin
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLD_CYCLES    = 300;
  localparam int PHASES         = 6;
  localparam int PHASE_WORDS    = 200;
  // settle time after the last verdict before a register write
  localparam int SETTLE_CYCLES  = 8;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [NOW_W-1:0]      now_ms;
  logic [9:0]            addr_slot;
  logic [11:0]           pair_slot;
  logic                  out_valid;
  logic                  out_stall;
  logic [VERDICT_W-1:0]  verdict;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int fail_count;
  int pending;

  // idle odds in percent for each side, and the hold-off request counter
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_req      = 0;
  int hold_done;

  // random traffic: a running clock and a few hot slots per phase
  logic [NOW_W-1:0] sim_now;
  logic [9:0]       hot_addr [4];
  logic [11:0]      hot_pair [8];
  int               step_max;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  two_level_login_rate_limiter u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .now_ms_i    (now_ms),
    .addr_slot_i (addr_slot),
    .pair_slot_i (pair_slot),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .verdict_o   (verdict),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  tllrl_verdict_tracker u_tracker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .now_ms_i     (now_ms),
    .addr_slot_i  (addr_slot),
    .pair_slot_i  (pair_slot),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .verdict_i    (verdict),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // result side: random stall at the falling edge, or one long hold-off when
  // the stimulus asks for it so the block backs up into its input
  initial begin
    out_stall = 1'b0;
    hold_done = 0;
    forever begin
      @(negedge clk);
      if (hold_req != hold_done) begin
        hold_done = hold_req;
        out_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        out_stall = ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // watchdog: any accepted word on any channel counts as progress
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("FAIL two_level_login_rate_limiter");
    $finish;
  end

  // offer one request word, with random idle cycles in front of it; returns
  // at the falling edge after the accept with valid still high, so the next
  // word follows back to back unless the sender idles
  task automatic send_word(input logic [NOW_W-1:0] now, input logic [9:0] a,
                           input logic [11:0] p);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid  = 1'b1;
    now_ms    = now;
    addr_slot = a;
    pair_slot = p;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // stop offering, let every verdict come back, then give the last request
  // time to finish its write-back
  task automatic quiesce();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  // all four registers back to back; also scales the random time step so
  // buckets drain at a rate comparable to the replenish intervals
  task automatic load_config(input logic [BURST_W-1:0] ab, input logic [IV_W-1:0] ai,
                             input logic [BURST_W-1:0] pb, input logic [IV_W-1:0] pi);
    write_reg(CFG_ADDR_BURST, CFG_DATA_W'(ab));
    write_reg(CFG_ADDR_IV,    CFG_DATA_W'(ai));
    write_reg(CFG_PAIR_BURST, CFG_DATA_W'(pb));
    write_reg(CFG_PAIR_IV,    CFG_DATA_W'(pi));
    cfg_valid = 1'b0;
    step_max  = (int'(ai) + int'(pi)) / 8 + 1;
  endtask

  // mostly hot-slot traffic on an advancing clock so buckets run dry, some
  // requests with time stepping back, the rest fully random words
  task automatic random_word();
    int pick;
    pick = $urandom_range(99);
    if (pick < 75) begin
      sim_now += NOW_W'($urandom_range(step_max));
      send_word(sim_now, hot_addr[$urandom_range(3)], hot_pair[$urandom_range(7)]);
    end else if (pick < 85) begin
      send_word(sim_now - NOW_W'($urandom_range(2 * step_max)),
                hot_addr[$urandom_range(3)], hot_pair[$urandom_range(7)]);
    end else begin
      send_word(NOW_W'({$urandom(), $urandom()}), 10'($urandom()), 12'($urandom()));
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    now_ms    = '0;
    addr_slot = '0;
    pair_slot = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_ADDR_BURST;
    cfg_data  = '0;
    sim_now   = '0;
    step_max  = 1;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // reset settings: address burst 5 / 1000 ms, pair burst 2 / 500 ms.
    // same slots at time zero: the third word runs out of pair tokens while
    // its address token stays spent
    send_word('0, 10'd0, 12'd0);
    send_word('0, 10'd0, 12'd0);
    send_word('0, 10'd0, 12'd0);
    // fresh pairs on the same address: two more pass, then the address is dry
    send_word('0, 10'd0, 12'd1);
    send_word('0, 10'd0, 12'd2);
    send_word('0, 10'd0, 12'd3);
    send_word('0, 10'd0, 12'd4);
    // top of every field, then time going backwards on the same slots
    send_word({NOW_W{1'b1}}, 10'h3FF, 12'hFFF);
    send_word(NOW_W'(100), 10'h3FF, 12'hFFF);
    // alternating bit patterns
    send_word(47'h2AAA_AAAA_AAAA, 10'h2AA, 12'hAAA);
    send_word(47'h5555_5555_5555, 10'h155, 12'h555);

    // address check off, pair burst and interval at the top of their widths
    quiesce();
    load_config(8'd0, 18'd0, 8'hFF, 18'h3FFFF);
    send_word(NOW_W'(5000), 10'd0, 12'd7);
    send_word(NOW_W'(5000), 10'd0, 12'd7);
    send_word(NOW_W'(5000), 10'd0, 12'd7);

    // zero address interval: denies only while the slot is still ahead of now;
    // single pair token with an interval of 200000 ms
    quiesce();
    load_config(8'hFF, 18'd0, 8'd1, 18'd200000);
    send_word(NOW_W'(10), 10'd3, 12'd9);
    send_word(NOW_W'(10), 10'd3, 12'd9);
    send_word(NOW_W'(5), 10'd3, 12'd9);
    send_word(NOW_W'(10), 10'd3, 12'd9);

    for (int ph = 0; ph < PHASES; ph++) begin
      quiesce();
      case (ph)
        0: load_config(8'd200, 18'd200000, 8'd200, 18'd200000);
        1: load_config(8'd1, 18'd5, 8'd1, 18'd5);
        2: load_config(8'($urandom_range(1, 6)), 18'($urandom_range(5, 3000)),
                       8'($urandom_range(1, 6)), 18'($urandom_range(5, 3000)));
        3: load_config(8'd0, 18'($urandom_range(5, 3000)),
                       8'($urandom_range(1, 4)), 18'($urandom_range(5, 3000)));
        4: load_config(8'($urandom_range(1, 4)), 18'($urandom_range(5, 3000)),
                       8'd0, 18'($urandom_range(5, 3000)));
        default: load_config(8'($urandom_range(1, 8)), 18'($urandom_range(5, 200000)),
                             8'($urandom_range(1, 8)), 18'($urandom_range(5, 200000)));
      endcase
      // fast sender with busy receiver, then the reverse, then full speed
      if (ph < 2) begin
        send_idle_pct = 11;
        recv_idle_pct = 87;
      end else if (ph < 4) begin
        send_idle_pct = 87;
        recv_idle_pct = 11;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      // long result hold-off while words keep coming at full rate
      if (ph == 4) hold_req++;
      foreach (hot_addr[i]) hot_addr[i] = 10'($urandom());
      foreach (hot_pair[i]) hot_pair[i] = 12'($urandom());
      // jump past anything the previous phase left in the tables
      sim_now += NOW_W'(64'd100_000_000);
      repeat (PHASE_WORDS) random_word();
    end

    quiesce();
    if (fail_count == 0 && pending == 0) begin
      $display("PASS two_level_login_rate_limiter");
    end else begin
      $display("FAIL two_level_login_rate_limiter");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/tllrl_pkg.sv
sv/two_level_login_rate_limiter.sv
sim/tllrl_verdict_tracker.sv
sim/tb_top.sv
